/* hw/rtl/tsht_pkg.sv */
// shared types and constants for the topmost shape hit test block
`default_nettype none
package tsht_pkg;

    localparam int MIN_POLY_VERTICES = 3;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_APPEND = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TABLE_FULL  = 2'd1,
        ST_VERTEX_FULL = 2'd2,
        ST_NO_SHAPE    = 2'd3
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic [15:0]        rect_width;
        logic [15:0]        rect_height;
        logic               is_polygon;
        logic               visible;
        logic signed [15:0] z_order;
        logic [15:0]        element_id;
        logic               blocks_scene;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [15:0] hit_id;
        logic        blocks_input;
        t_status     status;
    } t_out_item;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] z;
        logic [15:0]        id;
        logic               blocks;
        logic               poly;
    } t_attr;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [15:0]        w;
        logic [15:0]        h;
    } t_rect;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_vertex;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QATTR,
        S_QEVAL,
        S_VPREV,
        S_VCUR,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* hw/rtl/tsht_stream_if.sv */
// valid/ready stream interface carrying one payload item per transfer
`default_nettype none
interface tsht_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/topmost_shape_hit_test.sv */
// topmost shape hit test: shape table, vertex store and iterative point query
// clear, add and append offer their result in the cycle after the transfer
// query: per shape an attribute read and evaluation; per polygon a last vertex fetch; per edge
// a fetch, a product, a second product if it straddles the query row, and a compare;
// one shared 17x17 multiplier forms both; one item at a time; a waiting result blocks the next
// input transfer; reset (synchronous, active low) empties the table; stores are not cleared
`default_nettype none
module topmost_shape_hit_test
    import tsht_pkg::*;
#(
    parameter int MAX_SHAPES   = 32,
    parameter int MAX_VERTICES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tsht_stream_if.sink   i_in,
    tsht_stream_if.source o_out
);
    localparam int CNT_W = $clog2(MAX_SHAPES + 1);
    localparam int IDX_W = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int NV_W  = $clog2(MAX_VERTICES + 1);
    localparam int VDEP  = MAX_SHAPES * MAX_VERTICES;
    localparam int VA_W  = (VDEP > 1) ? $clog2(VDEP) : 1;
    localparam int AW    = $bits(t_attr) + NV_W;
    localparam logic [VA_W-1:0] VSTRIDE = VA_W'(MAX_VERTICES);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count, r_idx, n_idx;
    t_attr r_last_attr, n_last_attr;
    logic [NV_W-1:0] r_last_nv, n_last_nv, r_nv, n_nv, r_cur, n_cur;
    logic signed [15:0] r_qx, n_qx, r_qy, n_qy;
    logic signed [15:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;
    logic signed [15:0] r_bestz, n_bestz;
    logic [15:0] r_bestid, n_bestid;
    logic r_found, n_found, r_bestblk, n_bestblk, r_inside, n_inside;
    logic r_straddle, n_straddle, r_dypos, n_dypos;
    logic signed [33:0] r_lhs, n_lhs, r_rhs, n_rhs;
    logic r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // memory ports
    logic attr_we, rect_we, vtx_we;
    logic [IDX_W-1:0] attr_waddr;
    logic [AW-1:0] attr_wdata, attr_rdata;
    t_rect rect_wdata, rect_rd;
    t_attr attr_rd;
    logic [NV_W-1:0] nv_rd;
    logic [VA_W-1:0] vtx_waddr, vtx_raddr, base_q, base_last;
    t_vertex vtx_wdata, vtx_rd;

    // shared multiplier
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    // rectangle bounds
    logic signed [17:0] rect_r, rect_b;
    logic rect_hit;

    t_in_item in_d;
    logic in_xfer, out_free;

    assign in_d     = i_in.data;
    assign out_free = !r_out_valid || o_out.ready;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign {attr_rd, nv_rd} = attr_rdata;
    assign base_q    = VA_W'(r_idx[IDX_W-1:0]) * VSTRIDE;
    assign base_last = VA_W'(IDX_W'(r_count - 1'b1)) * VSTRIDE;

    tsht_ram #(.WIDTH(AW), .DEPTH(MAX_SHAPES)) u_attr_ram (
        .i_clk(i_clk), .i_we(attr_we), .i_waddr(attr_waddr), .i_wdata(attr_wdata),
        .i_raddr(r_idx[IDX_W-1:0]), .o_rdata(attr_rdata)
    );
    tsht_ram #(.WIDTH($bits(t_rect)), .DEPTH(MAX_SHAPES)) u_rect_ram (
        .i_clk(i_clk), .i_we(rect_we), .i_waddr(r_count[IDX_W-1:0]), .i_wdata(rect_wdata),
        .i_raddr(r_idx[IDX_W-1:0]), .o_rdata(rect_rd)
    );
    tsht_ram #(.WIDTH($bits(t_vertex)), .DEPTH(VDEP)) u_vtx_ram (
        .i_clk(i_clk), .i_we(vtx_we), .i_waddr(vtx_waddr), .i_wdata(vtx_wdata),
        .i_raddr(vtx_raddr), .o_rdata(vtx_rd)
    );

    // rectangle test, bounds formed wide enough to never wrap
    always_comb begin
        rect_r   = {{2{rect_rd.left[15]}}, rect_rd.left} + {2'b00, rect_rd.w};
        rect_b   = {{2{rect_rd.top[15]}}, rect_rd.top} + {2'b00, rect_rd.h};
        rect_hit = (r_qx >= rect_rd.left) && (r_qy >= rect_rd.top) &&
                   ($signed({{2{r_qx[15]}}, r_qx}) < rect_r) &&
                   ($signed({{2{r_qy[15]}}, r_qy}) < rect_b);
    end

    // multiplier operand select: lhs in the first pass, rhs in the second
    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = {r_qx[15], r_qx} - {r_ax[15], r_ax};
            mul_b = {r_by[15], r_by} - {r_ay[15], r_ay};
        end else begin
            mul_a = {r_bx[15], r_bx} - {r_ax[15], r_ax};
            mul_b = {r_qy[15], r_qy} - {r_ay[15], r_ay};
        end
        mul_p = mul_a * mul_b;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_last_attr <= n_last_attr;
        r_last_nv   <= n_last_nv;
        r_nv        <= n_nv;
        r_cur       <= n_cur;
        r_qx        <= n_qx;
        r_qy        <= n_qy;
        r_ax        <= n_ax;
        r_ay        <= n_ay;
        r_bx        <= n_bx;
        r_by        <= n_by;
        r_bestz     <= n_bestz;
        r_bestid    <= n_bestid;
        r_found     <= n_found;
        r_bestblk   <= n_bestblk;
        r_inside    <= n_inside;
        r_straddle  <= n_straddle;
        r_dypos     <= n_dypos;
        r_lhs       <= n_lhs;
        r_rhs       <= n_rhs;
        r_out       <= n_out;
    end

    // sequencer
    always_comb begin
        logic fin;
        logic fin_hit;
        logic left;
        t_attr new_attr;

        fin      = 1'b0;
        fin_hit  = 1'b0;
        left     = 1'b0;
        new_attr = '{visible: in_d.visible, z: in_d.z_order, id: in_d.element_id,
                     blocks: in_d.blocks_scene, poly: in_d.is_polygon};

        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_last_attr = r_last_attr;
        n_last_nv   = r_last_nv;
        n_nv        = r_nv;
        n_cur       = r_cur;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_bx        = r_bx;
        n_by        = r_by;
        n_bestz     = r_bestz;
        n_bestid    = r_bestid;
        n_found     = r_found;
        n_bestblk   = r_bestblk;
        n_inside    = r_inside;
        n_straddle  = r_straddle;
        n_dypos     = r_dypos;
        n_lhs       = r_lhs;
        n_rhs       = r_rhs;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        attr_we    = 1'b0;
        attr_waddr = r_count[IDX_W-1:0];
        attr_wdata = {new_attr, NV_W'(0)};
        rect_we    = 1'b0;
        rect_wdata = '{left: in_d.point_x, top: in_d.point_y,
                       w: in_d.rect_width, h: in_d.rect_height};
        vtx_we     = 1'b0;
        vtx_waddr  = base_last + VA_W'(r_last_nv);
        vtx_wdata  = '{x: in_d.point_x, y: in_d.point_y};
        vtx_raddr  = base_q;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_out = '{hit: 1'b0, hit_id: 16'd0, blocks_input: 1'b0, status: ST_OK};
                    n_out_valid = 1'b1;
                    case (in_d.mode)
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        MODE_ADD: begin
                            if (r_count == CNT_W'(MAX_SHAPES)) begin
                                n_out.status = ST_TABLE_FULL;
                            end else begin
                                attr_we     = 1'b1;
                                rect_we     = 1'b1;
                                n_last_attr = new_attr;
                                n_last_nv   = '0;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        MODE_APPEND: begin
                            if (r_count == '0 || !r_last_attr.poly) begin
                                n_out.status = ST_NO_SHAPE;
                            end else if (r_last_nv == NV_W'(MAX_VERTICES)) begin
                                n_out.status = ST_VERTEX_FULL;
                            end else begin
                                vtx_we     = 1'b1;
                                attr_we    = 1'b1;
                                attr_waddr = IDX_W'(r_count - 1'b1);
                                attr_wdata = {r_last_attr, NV_W'(r_last_nv + 1'b1)};
                                n_last_nv  = r_last_nv + 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            n_qx    = in_d.point_x;
                            n_qy    = in_d.point_y;
                            n_found = 1'b0;
                            n_idx   = '0;
                            if (r_count != '0) begin
                                n_out_valid = r_out_valid && !o_out.ready;
                                n_state     = S_QATTR;
                            end
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            S_QATTR: begin
                n_state = S_QEVAL;
            end
            S_QEVAL: begin
                if (!attr_rd.visible) begin
                    fin = 1'b1;
                end else if (!attr_rd.poly) begin
                    fin     = 1'b1;
                    fin_hit = rect_hit;
                end else if (nv_rd < NV_W'(MIN_POLY_VERTICES)) begin
                    fin = 1'b1;
                end else begin
                    n_nv      = nv_rd;
                    n_cur     = '0;
                    n_inside  = 1'b0;
                    vtx_raddr = base_q + VA_W'(nv_rd - 1'b1);
                    n_state   = S_VPREV;
                end
            end
            S_VPREV: begin
                n_bx    = vtx_rd.x;
                n_by    = vtx_rd.y;
                n_state = S_VCUR;
            end
            S_VCUR: begin
                n_ax    = vtx_rd.x;
                n_ay    = vtx_rd.y;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_straddle = (r_ay > r_qy) != (r_by > r_qy);
                n_lhs      = mul_p;
                n_dypos    = r_by > r_ay;
                n_state    = ((r_ay > r_qy) != (r_by > r_qy)) ? S_MUL2 : S_CMP;
            end
            S_MUL2: begin
                n_rhs   = mul_p;
                n_state = S_CMP;
            end
            S_CMP: begin
                left     = r_dypos ? (r_lhs < r_rhs) : (r_lhs > r_rhs);
                n_inside = r_inside ^ (r_straddle && left);
                n_bx     = r_ax;
                n_by     = r_ay;
                n_cur    = r_cur + 1'b1;
                if (NV_W'(r_cur + 1'b1) == r_nv) begin
                    fin     = 1'b1;
                    fin_hit = n_inside;
                end else begin
                    vtx_raddr = base_q + VA_W'(r_cur + 1'b1);
                    n_state   = S_VCUR;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out = '{hit: r_found, hit_id: r_found ? r_bestid : 16'd0,
                              blocks_input: r_found && r_bestblk, status: ST_OK};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // close one shape: keep the highest z, earliest on a tie
        if (fin) begin
            if (fin_hit && (!r_found || attr_rd.z > r_bestz)) begin
                n_found   = 1'b1;
                n_bestz   = attr_rd.z;
                n_bestid  = attr_rd.id;
                n_bestblk = attr_rd.blocks;
            end
            n_idx   = r_idx + 1'b1;
            n_state = (CNT_W'(r_idx + 1'b1) == r_count) ? S_DONE : S_QATTR;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/tsht_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module tsht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/tsht_checker.sv */
// port-level checks for the topmost shape hit test, bound to the top level
`default_nettype none
module tsht_checker
    import tsht_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // a miss reports id and blocks flag as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.hit |-> i_out_data.hit_id == 16'd0 &&
        !i_out_data.blocks_input)
        else $error("miss with nonzero id or blocks flag");

    // a hit only comes from a query, whose status is ok
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.hit |-> i_out_data.status == ST_OK)
        else $error("hit with error status");

    // an input transfer never overruns a waiting result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || i_out_ready)
        else $error("input taken while result stalled");

    // after an input transfer the result is offered or the input stalls
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid || !i_in_ready)
        else $error("input ready again with no result offered");
endmodule

bind topmost_shape_hit_test tsht_checker u_tsht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_data (o_out.data)
);
`default_nettype wire
